// File: rtl/npss_pkg.sv
// ----------------------------------------------------------------------------
// npss_pkg: shared types and constants of the next prime search unit
// Holds the sequencer state codes, the divisor kinds and the fixed constants
// of the 6k-1 / 6k+1 trial division scheme.
// ----------------------------------------------------------------------------
`default_nettype none

package npss_pkg;

  // Sequencer states of the search.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_SQCHK,
    ST_SQUPD,
    ST_DONE
  } state_e;

  // Which divisor the shared remainder unit is working on.
  typedef enum logic [1:0] {
    DK_MOD3,
    DK_LO,
    DK_HI
  } div_kind_e;

  localparam int unsigned SmallPrimeA = 2;
  localparam int unsigned SmallPrimeB = 3;
  localparam int unsigned FirstDiv    = 5;
  localparam int unsigned DivStep     = 6;
  localparam int unsigned PairGap     = 2;
  localparam int unsigned FirstSq     = FirstDiv * FirstDiv;
  localparam int unsigned SqStep      = DivStep * DivStep;

endpackage : npss_pkg

`default_nettype wire

// File: rtl/next_prime_search_unit.sv
// ----------------------------------------------------------------------------
// next_prime_search_unit: finds the first prime at or above a start value
// Trial division by 3 and by the pairs 6k-1, 6k+1 on one shared
// bit-serial remainder unit, driven by a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata (low bit up)             tuser
// s_axis    in   start_value[30:0], 1 pad bit   -
// m_axis    out  prime_value[31:0]              found
//
// Timing: one item takes a data-dependent time. Every remainder c mod d runs
// in the shared restoring remainder unit (one quotient bit per cycle), followed
// by an evaluate step. A candidate that survives the parity test costs about
// (1 + 2*sqrt(c)/6) remainders plus a square update and check per divisor
// pair; even candidates take a single check step each. The remainder unit is
// the only arithmetic that iterates, so it dominates the time per item.
// Reset: asynchronous, active low; it clears the sequencer and the output
// valid. Stalls: a new start value is taken as soon as the sequencer is idle,
// even while the previous result still waits in the output register; a
// finished search waits for that register to free up before it loads it.
// ----------------------------------------------------------------------------
`default_nettype none

module next_prime_search_unit
  import npss_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Start values.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] start_value, [31] zero pad
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] prime_value
  output logic        m_axis_tuser    // [0] found
);

  // Candidates carry one bit more than the datapath so that running past the
  // top of the datapath range shows up as the upper bit.
  localparam int unsigned CW   = VALUE_WIDTH + 1;
  localparam int unsigned SQW  = 2 * CW;
  localparam int unsigned CNTW = $clog2(CW);
  // Bits of the start value that survive the datapath width.
  localparam int unsigned SW   = (VALUE_WIDTH < 31) ? VALUE_WIDTH : 31;

  state_e          state_q, state_d;
  div_kind_e       kind_q, kind_d;
  logic [CW-1:0]   cand_q, cand_d;
  logic [CW-1:0]   limit_q, limit_d;
  logic [CW-1:0]   d_q, d_d;        // current 6k-1 divisor
  logic [SQW-1:0]  sq_q, sq_d;      // square of d_q, kept by increments
  logic [CW-1:0]   div_q, div_d;    // divisor in the remainder unit
  logic [CW-1:0]   rem_q, rem_d;    // partial remainder
  logic [CW-1:0]   quo_q, quo_d;    // dividend bits still to shift in
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            found_q, found_d;
  logic            m_valid_q, m_valid_d;
  logic [31:0]     out_value_q, out_value_d;
  logic            out_found_q, out_found_d;

  logic [CW-1:0]   start_m;
  logic [CW:0]     trial;

  // The start value is taken modulo 2^min(VALUE_WIDTH, 31).
  assign start_m = CW'(s_axis_tdata[SW-1:0]);
  // One restoring step: bring down the next dividend bit.
  assign trial   = {rem_q, quo_q[CW-1]};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    cand_q      <= cand_d;
    limit_q     <= limit_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    found_q     <= found_d;
    out_value_q <= out_value_d;
    out_found_q <= out_found_d;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    cand_d      = cand_q;
    limit_d     = limit_q;
    d_d         = d_q;
    sq_d        = sq_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    out_value_d = out_value_q;
    out_found_d = out_found_q;
    m_valid_d   = m_valid_q;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cand_d  = start_m;
          limit_d = start_m << 1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // The search ends at twice the start or at the top of the datapath.
        if (cand_q >= limit_q || cand_q[CW-1]) begin
          found_d = 1'b0;
          state_d = ST_DONE;
        end else if (cand_q == CW'(SmallPrimeA) || cand_q == CW'(SmallPrimeB)) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else if (cand_q < CW'(SmallPrimeA) || !cand_q[0]) begin
          // Zero, one and even numbers are not prime.
          cand_d = cand_q + CW'(1);
        end else begin
          div_d   = CW'(SmallPrimeB);
          kind_d  = DK_MOD3;
          rem_d   = '0;
          quo_d   = cand_q;
          cnt_d   = CNTW'(CW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = CW'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[CW-1:0];
        end
        quo_d = quo_q << 1;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (rem_q == '0) begin
          // A divisor hit: move on to the next candidate.
          cand_d  = cand_q + CW'(1);
          state_d = ST_CHECK;
        end else begin
          case (kind_q)
            DK_MOD3: begin
              d_d     = CW'(FirstDiv);
              sq_d    = SQW'(FirstSq);
              state_d = ST_SQCHK;
            end
            DK_LO: begin
              div_d   = d_q + CW'(PairGap);
              kind_d  = DK_HI;
              rem_d   = '0;
              quo_d   = cand_q;
              cnt_d   = CNTW'(CW - 1);
              state_d = ST_DIV;
            end
            default: begin
              state_d = ST_SQUPD;
            end
          endcase
        end
      end
      ST_SQUPD: begin
        // (d+6)^2 = d^2 + 12d + 36
        sq_d    = sq_q + (SQW'(d_q) << 3) + (SQW'(d_q) << 2) + SQW'(SqStep);
        d_d     = d_q + CW'(DivStep);
        state_d = ST_SQCHK;
      end
      ST_SQCHK: begin
        if (sq_q > SQW'(cand_q)) begin
          // No divisor up to the square root: the candidate is prime.
          found_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_d   = d_q;
          kind_d  = DK_LO;
          rem_d   = '0;
          quo_d   = cand_q;
          cnt_d   = CNTW'(CW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_value_d = found_q ? 32'(cand_q) : 32'd0;
          out_found_d = found_q;
          m_valid_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule : next_prime_search_unit

`default_nettype wire

// File: rtl/npss_checker.sv
// ----------------------------------------------------------------------------
// npss_checker: port-level checks of the next prime search unit
// Watches the two stream channels and the shape of the results.
// ----------------------------------------------------------------------------
`default_nettype none

module npss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A search is busy for at least the cycle after a start value transfer.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("start value taken while a search runs");

  // A miss reports a zero value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("miss with nonzero value");

  // A hit is two or an odd number above one.
  a_hit_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata == 32'd2 || (m_axis_tdata[0] && m_axis_tdata != 32'd1))
    else $error("reported prime has an impossible value");

endmodule : npss_checker

bind next_prime_search_unit npss_checker u_npss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
